@@ design/tlv_header_parser_core_assert.svh @@
// Assertion macros for the TLV header parser core.
`ifndef TLV_HEADER_PARSER_CORE_ASSERT_SVH
`define TLV_HEADER_PARSER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition ante implies cons in the same cycle.
`define TLV_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlv_header_parser_core: assertion failed");

// Condition ante implies cons in the next cycle.
`define TLV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlv_header_parser_core: assertion failed");

`else

`define TLV_ASSERT_SAME(label, clk, rst, ante, cons)
`define TLV_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ design/tlvhp_pkg.sv @@
package tlvhp_pkg;

  // Largest frame that is not flagged as too long.
  localparam int unsigned MAX_FRAME_BYTES = 4096;

  // Byte counter saturates at MAX_FRAME_BYTES + 1.
  localparam int unsigned COUNT_W = $clog2(MAX_FRAME_BYTES + 2);

  // Field widths of the result.
  localparam int unsigned LEN_W   = 24;
  localparam int unsigned IDENT_W = 16;
  localparam int unsigned HDR_W   = 3;
  localparam int unsigned TOTAL_W = 13;

  // Width for header size plus value length against the byte count.
  localparam int unsigned SUM_W = LEN_W + 1;
  localparam int unsigned CMP_W = (COUNT_W > SUM_W) ? COUNT_W : SUM_W;

  // Header phases.
  localparam logic [2:0] PH_TYPE = 3'd0;
  localparam logic [2:0] PH_ID1  = 3'd1;
  localparam logic [2:0] PH_ID2  = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;
  localparam logic [1:0] ST_LONG    = 2'd3;

  // Type byte masks.
  localparam logic [7:0] TYPE_ID_MASK   = 8'hC0;
  localparam logic [7:0] TYPE_WIDE_MASK = 8'h20;
  localparam logic [1:0] LEN_SIZE_MASK  = 2'h3;
  localparam logic [7:0] LEN_INL_MASK   = 8'h07;

endpackage

@@ design/tlv_header_parser_core.sv @@
// TLV header parser core: decodes the leading TLV header of a byte stream.
// Throughput: one byte per cycle while in_ready is high; each byte updates a small set of registers.
// The result appears in the cycle after the frame's last byte is taken.
// The result register stalls input only while a result waits and out_ready is low.
// Reset (rst, synchronous, active high) clears the header state and out_valid.
module tlv_header_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [1:0]  id_type,
  output logic [15:0] ident,
  output logic [2:0]  value_start,
  output logic [23:0] value_bytes,
  output logic [12:0] total_len
);

  `include "tlv_header_parser_core_assert.svh"

  // Header state
  logic [tlvhp_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic [2:0]                    phase, phase_next;
  logic [1:0]                    type_bits, type_bits_next;
  logic                          wide_ident, wide_ident_next;
  logic [1:0]                    length_bytes_left, length_bytes_left_next;
  logic [tlvhp_pkg::IDENT_W-1:0] ident_acc, ident_acc_next;
  logic [tlvhp_pkg::LEN_W-1:0]   length_acc, length_acc_next;
  logic [tlvhp_pkg::HDR_W-1:0]   header_size, header_size_next;

  logic                          accept;
  logic [1:0]                    len_left_dec;
  logic [tlvhp_pkg::CMP_W-1:0]   total_sum;
  logic                          too_long;
  logic                          too_short;
  logic                          overrun;
  logic [1:0]                    status_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign len_left_dec = length_bytes_left - 2'd1;

  // Advance the header decode by one byte
  always_comb begin
    type_bits_next         = type_bits;
    wide_ident_next        = wide_ident;
    length_bytes_left_next = length_bytes_left;
    ident_acc_next         = ident_acc;
    length_acc_next        = length_acc;
    header_size_next       = header_size;
    phase_next             = phase;

    if (byte_count <= tlvhp_pkg::COUNT_W'(tlvhp_pkg::MAX_FRAME_BYTES)) begin
      byte_count_next = byte_count + 1'b1;
    end else begin
      byte_count_next = byte_count;
    end

    case (phase)
      tlvhp_pkg::PH_TYPE: begin
        type_bits_next         = 2'((data_byte & tlvhp_pkg::TYPE_ID_MASK) >> 6);
        wide_ident_next        = |(data_byte & tlvhp_pkg::TYPE_WIDE_MASK);
        length_bytes_left_next = data_byte[4:3] & tlvhp_pkg::LEN_SIZE_MASK;
        if (data_byte[4:3] == 2'd0) begin
          length_acc_next = tlvhp_pkg::LEN_W'(data_byte & tlvhp_pkg::LEN_INL_MASK);
        end else begin
          length_acc_next = '0;
        end
        ident_acc_next   = '0;
        header_size_next = tlvhp_pkg::HDR_W'(1);
        phase_next       = tlvhp_pkg::PH_ID1;
      end
      tlvhp_pkg::PH_ID1: begin
        ident_acc_next   = tlvhp_pkg::IDENT_W'(data_byte);
        header_size_next = header_size + 1'b1;
        if (wide_ident) begin
          phase_next = tlvhp_pkg::PH_ID2;
        end else if (length_bytes_left != 2'd0) begin
          phase_next = tlvhp_pkg::PH_LEN;
        end else begin
          phase_next = tlvhp_pkg::PH_DONE;
        end
      end
      tlvhp_pkg::PH_ID2: begin
        ident_acc_next   = {ident_acc[7:0], data_byte};
        header_size_next = header_size + 1'b1;
        if (length_bytes_left != 2'd0) begin
          phase_next = tlvhp_pkg::PH_LEN;
        end else begin
          phase_next = tlvhp_pkg::PH_DONE;
        end
      end
      tlvhp_pkg::PH_LEN: begin
        length_acc_next        = {length_acc[tlvhp_pkg::LEN_W-9:0], data_byte};
        header_size_next       = header_size + 1'b1;
        length_bytes_left_next = len_left_dec;
        if (len_left_dec == 2'd0) begin
          phase_next = tlvhp_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Classify the frame from the state after its last byte
  assign total_sum = tlvhp_pkg::CMP_W'(header_size_next)
                   + tlvhp_pkg::CMP_W'(length_acc_next);
  assign too_long  = byte_count_next > tlvhp_pkg::COUNT_W'(tlvhp_pkg::MAX_FRAME_BYTES);
  assign too_short = (byte_count_next < tlvhp_pkg::COUNT_W'(2))
                  || (phase_next != tlvhp_pkg::PH_DONE);
  assign overrun   = total_sum > tlvhp_pkg::CMP_W'(byte_count_next);

  always_comb begin
    if (too_long) begin
      status_next = tlvhp_pkg::ST_LONG;
    end else if (too_short) begin
      status_next = tlvhp_pkg::ST_SHORT;
    end else if (overrun) begin
      status_next = tlvhp_pkg::ST_OVERRUN;
    end else begin
      status_next = tlvhp_pkg::ST_OK;
    end
  end

  // Update header state; clear it after the frame's last byte
  always_ff @(posedge clk) begin
    if (rst || (accept && frame_last)) begin
      byte_count        <= '0;
      phase             <= tlvhp_pkg::PH_TYPE;
      type_bits         <= '0;
      wide_ident        <= 1'b0;
      length_bytes_left <= '0;
      ident_acc         <= '0;
      length_acc        <= '0;
      header_size       <= '0;
    end else if (accept) begin
      byte_count        <= byte_count_next;
      phase             <= phase_next;
      type_bits         <= type_bits_next;
      wide_ident        <= wide_ident_next;
      length_bytes_left <= length_bytes_left_next;
      ident_acc         <= ident_acc_next;
      length_acc        <= length_acc_next;
      header_size       <= header_size_next;
    end
  end

  // Result valid: set on a last byte, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && frame_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: fields but status are zero for short or long frames; total_len is zero on overrun
  always_ff @(posedge clk) begin
    if (accept && frame_last) begin
      status <= status_next;
      if (too_long || too_short) begin
        id_type     <= '0;
        ident       <= '0;
        value_start <= '0;
        value_bytes <= '0;
        total_len   <= '0;
      end else begin
        id_type     <= type_bits_next;
        ident       <= ident_acc_next;
        value_start <= header_size_next;
        value_bytes <= length_acc_next;
        if (overrun) begin
          total_len <= '0;
        end else begin
          total_len <= total_sum[tlvhp_pkg::TOTAL_W-1:0];
        end
      end
    end
  end

  // Checks
  `TLV_ASSERT_NEXT(a_last_gives_result, clk, rst, accept && frame_last, out_valid)
  `TLV_ASSERT_NEXT(a_last_clears_state, clk, rst, accept && frame_last,
                   phase == tlvhp_pkg::PH_TYPE && byte_count == '0)
  `TLV_ASSERT_SAME(a_bad_total_zero, clk, rst, out_valid && status != tlvhp_pkg::ST_OK,
                   total_len == '0)
  `TLV_ASSERT_SAME(a_ok_hdr_size, clk, rst, out_valid && status == tlvhp_pkg::ST_OK,
                   value_start >= 3'd2 && value_start <= 3'd6)

endmodule

@@ sim/tlv_frame_checker.sv @@
module tlv_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [1:0]  id_type,
  input  logic [15:0] ident,
  input  logic [2:0]  value_start,
  input  logic [23:0] value_bytes,
  input  logic [12:0] total_len,
  output int          mismatch_count,
  output int          headers_due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  id_type;
    logic [15:0] ident;
    logic [2:0]  value_start;
    logic [23:0] value_bytes;
    logic [12:0] total_len;
  } tlv_header_t;

  // Decoded headers waiting for the block to report them, oldest first.
  tlv_header_t headers_due[$];
  tlv_header_t got;
  tlv_header_t want;

  // Shadow copy of the header decode state.
  logic [tlvhp_pkg::COUNT_W-1:0] seen_bytes;
  logic [2:0]                    hdr_phase;
  logic [1:0]                    type_code;
  logic                          wide_id;
  logic [1:0]                    len_bytes_left;
  logic [15:0]                   ident_acc;
  logic [23:0]                   len_acc;
  logic [2:0]                    head_bytes;
  logic [tlvhp_pkg::CMP_W-1:0]   tlv_total;

  task automatic clear_header();
    seen_bytes     = '0;
    hdr_phase      = tlvhp_pkg::PH_TYPE;
    type_code      = '0;
    wide_id        = 1'b0;
    len_bytes_left = '0;
    ident_acc      = '0;
    len_acc        = '0;
    head_bytes     = '0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_header();
      headers_due.delete();
      mismatch_count = 0;
    end else begin
      // Compare a reported header with the oldest one predicted.
      if (out_valid && out_ready) begin
        got = '{status, id_type, ident, value_start, value_bytes, total_len};
        if (headers_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("tlv_frame_checker: result with none pending: st=%0d typ=%0d id=%h",
                     got.status, got.id_type, got.ident);
          mismatch_count++;
        end else begin
          want = headers_due.pop_front();
          if (got.status != want.status || got.id_type != want.id_type ||
              got.ident != want.ident || got.value_start != want.value_start ||
              got.value_bytes != want.value_bytes || got.total_len != want.total_len) begin
            if (mismatch_count < 10) begin
              $display("tlv_frame_checker: expected st=%0d typ=%0d id=%h off=%0d len=%0d tot=%0d",
                       want.status, want.id_type, want.ident, want.value_start,
                       want.value_bytes, want.total_len);
              $display("tlv_frame_checker: actual   st=%0d typ=%0d id=%h off=%0d len=%0d tot=%0d",
                       got.status, got.id_type, got.ident, got.value_start,
                       got.value_bytes, got.total_len);
            end
            mismatch_count++;
          end
        end
      end

      // Advance the decode on each accepted item.
      if (in_valid && in_ready) begin
        if (seen_bytes <= tlvhp_pkg::MAX_FRAME_BYTES)
          seen_bytes++;
        case (hdr_phase)
          tlvhp_pkg::PH_TYPE: begin
            type_code      = 2'((data_byte & tlvhp_pkg::TYPE_ID_MASK) >> 6);
            wide_id        = |(data_byte & tlvhp_pkg::TYPE_WIDE_MASK);
            len_bytes_left = 2'(data_byte >> 3) & tlvhp_pkg::LEN_SIZE_MASK;
            len_acc        = (len_bytes_left == 0) ?
                             24'(data_byte & tlvhp_pkg::LEN_INL_MASK) : '0;
            ident_acc      = '0;
            head_bytes     = 3'd1;
            hdr_phase      = tlvhp_pkg::PH_ID1;
          end
          tlvhp_pkg::PH_ID1: begin
            ident_acc = {8'h00, data_byte};
            head_bytes++;
            if (wide_id)
              hdr_phase = tlvhp_pkg::PH_ID2;
            else
              hdr_phase = (len_bytes_left != 0) ? tlvhp_pkg::PH_LEN : tlvhp_pkg::PH_DONE;
          end
          tlvhp_pkg::PH_ID2: begin
            ident_acc = {ident_acc[7:0], data_byte};
            head_bytes++;
            hdr_phase = (len_bytes_left != 0) ? tlvhp_pkg::PH_LEN : tlvhp_pkg::PH_DONE;
          end
          tlvhp_pkg::PH_LEN: begin
            len_acc = {len_acc[15:0], data_byte};
            head_bytes++;
            len_bytes_left--;
            if (len_bytes_left == 0)
              hdr_phase = tlvhp_pkg::PH_DONE;
          end
          default: begin
          end
        endcase

        // Close the frame: long beats short, short beats overrun.
        if (frame_last) begin
          want = '0;
          tlv_total = tlvhp_pkg::CMP_W'(head_bytes) + tlvhp_pkg::CMP_W'(len_acc);
          if (seen_bytes > tlvhp_pkg::MAX_FRAME_BYTES) begin
            want.status = tlvhp_pkg::ST_LONG;
          end else if (seen_bytes < 2 || hdr_phase != tlvhp_pkg::PH_DONE) begin
            want.status = tlvhp_pkg::ST_SHORT;
          end else begin
            want.id_type     = type_code;
            want.ident       = ident_acc;
            want.value_start = head_bytes;
            want.value_bytes = len_acc;
            if (tlv_total > tlvhp_pkg::CMP_W'(seen_bytes)) begin
              want.status = tlvhp_pkg::ST_OVERRUN;
            end else begin
              want.status    = tlvhp_pkg::ST_OK;
              want.total_len = tlv_total[12:0];
            end
          end
          headers_due.push_back(want);
          clear_header();
        end
      end
    end
    headers_due_count = headers_due.size();
  end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Slowest run is near 2.6k bytes with idle gaps and stalls; keep well clear of it.
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_BYTES = 1800;

  typedef enum int {FR_GOOD, FR_OVERRUN, FR_CUT, FR_NOISE} frame_kind_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        frame_last;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [1:0]  id_type;
  logic [15:0] ident;
  logic [2:0]  value_start;
  logic [23:0] value_bytes;
  logic [12:0] total_len;
  int          mismatch_count;
  int          due_count;

  bit          idle_on;
  logic [7:0]  frame_q[$];
  int          bytes_sent;
  int          frames_sent;
  int          random_bytes;
  int          kind_count[4];
  int          pick;
  frame_kind_t kind;

  tlv_header_parser_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .frame_last(frame_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .id_type(id_type), .ident(ident),
    .value_start(value_start), .value_bytes(value_bytes), .total_len(total_len)
  );

  tlv_frame_checker frame_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .frame_last(frame_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .id_type(id_type), .ident(ident),
    .value_start(value_start), .value_bytes(value_bytes), .total_len(total_len),
    .mismatch_count(mismatch_count), .headers_due_count(due_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // End the run if it hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  // Stall the result side in short random bursts.
  initial begin
    out_ready = 1'b1;
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  // Present one item and hold it until taken; returns on a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    frame_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i])
      send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  task automatic put_random(input int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  // Hold off the sender until every header has been reported.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_count != 0) @(negedge clk);
  endtask

  // Build a frame of the given kind with random content.
  task automatic make_frame(input frame_kind_t fk);
    logic [1:0]  idt;
    logic        wide;
    logic [1:0]  lsize;
    logic [15:0] idv;
    int          vlen;
    int          hlen;
    int          plen;
    int          keep;
    frame_q.delete();
    idt   = 2'($urandom);
    wide  = 1'($urandom);
    lsize = 2'($urandom);
    idv   = 16'($urandom);
    plen  = 0;
    if (fk == FR_NOISE) begin
      put_random($urandom_range(1, 8));
      return;
    end
    if (lsize == 0)
      vlen = $urandom_range(0, 7);
    else if (lsize != 1 && $urandom_range(0, 15) == 0)
      vlen = $urandom_range(256, 700);
    else
      vlen = $urandom_range(0, 40);
    if (fk == FR_OVERRUN && lsize != 0 && $urandom_range(0, 1) == 0)
      vlen = $urandom & ((1 << (8 * lsize)) - 1);
    if (fk == FR_OVERRUN && vlen == 0)
      vlen = 1;
    frame_q.push_back({idt, wide, lsize, (lsize == 0) ? 3'(vlen) : 3'($urandom)});
    if (wide)
      frame_q.push_back(idv[15:8]);
    frame_q.push_back(idv[7:0]);
    for (int k = lsize; k > 0; k--)
      frame_q.push_back(vlen[8 * (k - 1) +: 8]);
    hlen = frame_q.size();
    case (fk)
      FR_GOOD:    plen = vlen + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      FR_OVERRUN: plen = $urandom_range(0, (vlen > 10) ? 10 : vlen - 1);
      FR_CUT: begin
        keep = $urandom_range(1, hlen - 1);
        while (frame_q.size() > keep) void'(frame_q.pop_back());
      end
      default: begin
      end
    endcase
    put_random(plen);
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    data_byte  = 8'h00;
    frame_last = 1'b0;
    idle_on    = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: single byte, all-ones header, inline lengths, each id type,
    // each length size, cut headers, trailing bytes.
    frame_q = '{8'h00};
    send_frame();
    frame_q = '{8'h00, 8'hFF};
    send_frame();
    frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    frame_q = '{8'h07, 8'h12};
    put_random(8);
    send_frame();
    frame_q = '{8'h27, 8'hAB, 8'hCD, 8'h01};
    send_frame();
    frame_q = '{8'h41, 8'h00, 8'h55};
    send_frame();
    frame_q = '{8'h82, 8'h80, 8'h01, 8'h02};
    send_frame();
    frame_q = '{8'hC8, 8'h7F, 8'h03};
    put_random(3);
    send_frame();
    frame_q = '{8'hF0, 8'h12, 8'h34, 8'h00, 8'h02, 8'hAA, 8'h55};
    send_frame();
    frame_q = '{8'h38, 8'hFF, 8'hFF};
    send_frame();
    frame_q = '{8'h20, 8'h01};
    send_frame();
    frame_q = '{8'h18, 8'h01, 8'h00, 8'h00, 8'h01, 8'h99};
    send_frame();
    frame_q = '{8'h00, 8'h01};
    send_frame();
    drain();

    // Random: mostly well formed frames, some overruns, cut headers and noise.
    while (random_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0)
        idle_on = !idle_on;
      if (random_bytes > RANDOM_BYTES * 4 / 5)
        idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 70)
        kind = FR_GOOD;
      else if (pick < 80)
        kind = FR_OVERRUN;
      else if (pick < 90)
        kind = FR_CUT;
      else
        kind = FR_NOISE;
      make_frame(kind);
      kind_count[kind]++;
      random_bytes += frame_q.size();
      send_frame();
      if ($urandom_range(0, 39) == 0)
        drain();
    end

    drain();
    repeat (8) @(negedge clk);
    $display("tb_top: %0d bytes in %0d frames, with idle gaps on both sides",
             bytes_sent, frames_sent);
    $display("tb_top: random frames: %0d well formed, %0d overrun, %0d cut header, %0d noise",
             kind_count[FR_GOOD], kind_count[FR_OVERRUN], kind_count[FR_CUT],
             kind_count[FR_NOISE]);
    if (mismatch_count == 0 && due_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
